// ===== rtl/modular_2d_range_product_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle product block
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef MODULAR_2D_RANGE_PRODUCT_TOP_ASSERT_SVH
`define MODULAR_2D_RANGE_PRODUCT_TOP_ASSERT_SVH

// Check cons in the same cycle whenever ante holds
`define MRP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds
`define MRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types and constants of the rectangle product block.
// ----------------------------------------------------------------------------
package mrp_pkg;

    localparam int unsigned DEF_MAX_ROWS = 64;
    localparam int unsigned DEF_MAX_COLS = 64;

    localparam int VAL_W = 30;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } reg_idx_t;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic             is_query;
        logic             bad;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] top_row;
        logic [IDX_W-1:0] left_col;
        logic [IDX_W-1:0] bottom_row;
        logic [IDX_W-1:0] right_col;
    } item_t;

endpackage

// ===== rtl/mrp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mrp_mulmod
// Modular multiplier: interleaved double-and-add, one bit of b per cycle.
// ----------------------------------------------------------------------------
module mrp_mulmod (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [mrp_pkg::VAL_W-1:0] a,
    input  logic [mrp_pkg::VAL_W-1:0] b,
    output logic                    done,
    output logic [mrp_pkg::VAL_W-1:0] y
);
    import mrp_pkg::*;

    localparam int STEP_W = $clog2(VAL_W);

    logic             run_reg;
    logic             done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [VAL_W-1:0] a_reg;
    logic [VAL_W-1:0] b_reg;
    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W:0]   dbl;
    logic [VAL_W:0]   dbl_red;
    logic [VAL_W:0]   sum;
    logic [VAL_W:0]   sum_red;

    // Double the accumulator, reduce, add a when the bit is set, reduce
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
        sum     = dbl_red + (b_reg[VAL_W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, PRIME}) ? sum - {1'b0, PRIME} : sum;
    end

    // Step through the bits of b from the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= STEP_W'(VAL_W - 1);
                a_reg   <= a;
                b_reg   <= b;
                acc_reg <= '0;
            end
            else if (run_reg)
            begin
                acc_reg <= sum_red[VAL_W-1:0];
                b_reg   <= {b_reg[VAL_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign y    = acc_reg;

endmodule

// ===== rtl/mrp_inv.sv =====
// ----------------------------------------------------------------------------
// mrp_inv
// Modular inverse by binary extended Euclid, one halving or subtract a cycle.
// ----------------------------------------------------------------------------
module mrp_inv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mrp_pkg::VAL_W-1:0] a,
    output logic                      done,
    output logic [mrp_pkg::VAL_W-1:0] y
);
    import mrp_pkg::*;

    logic             run_reg;
    logic             done_reg;
    logic [VAL_W-1:0] u_reg;
    logic [VAL_W-1:0] v_reg;
    logic [VAL_W-1:0] x1_reg;
    logic [VAL_W-1:0] x2_reg;
    logic [VAL_W-1:0] y_reg;

    // Halve x modulo the prime
    function automatic logic [VAL_W-1:0] half_mod(input logic [VAL_W-1:0] x);
        logic [VAL_W:0] s;
        s = x[0] ? ({1'b0, x} + {1'b0, PRIME}) : {1'b0, x};
        return s[VAL_W:1];
    endfunction

    // Subtract modulo the prime
    function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] p,
                                                 input logic [VAL_W-1:0] q);
        logic [VAL_W-1:0] d;
        d = (p >= q) ? p - q : p + (PRIME - q);
        return d;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // Zero has no inverse: answer zero at once
                if (a == '0)
                begin
                    y_reg    <= '0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                    u_reg   <= a;
                    v_reg   <= PRIME;
                    x1_reg  <= VAL_W'(1);
                    x2_reg  <= '0;
                end
            end
            else if (run_reg)
            begin
                priority if (u_reg == VAL_W'(1))
                begin
                    y_reg    <= x1_reg;
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else if (v_reg == VAL_W'(1))
                begin
                    y_reg    <= x2_reg;
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else if (!u_reg[0])
                begin
                    u_reg  <= u_reg >> 1;
                    x1_reg <= half_mod(x1_reg);
                end
                else if (!v_reg[0])
                begin
                    v_reg  <= v_reg >> 1;
                    x2_reg <= half_mod(x2_reg);
                end
                else if (u_reg >= v_reg)
                begin
                    u_reg  <= u_reg - v_reg;
                    x1_reg <= sub_mod(x1_reg, x2_reg);
                end
                else
                begin
                    v_reg  <= v_reg - u_reg;
                    x2_reg <= sub_mod(x2_reg, x1_reg);
                end
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

// ===== rtl/mrp_front.sv =====
// ----------------------------------------------------------------------------
// mrp_front
// Accepts commands, checks query corners, reduces elements, queues items.
// ----------------------------------------------------------------------------
module mrp_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      cmd,
    input  logic [mrp_pkg::VAL_W-1:0] elem_value,
    input  logic [mrp_pkg::IDX_W-1:0] top_row,
    input  logic [mrp_pkg::IDX_W-1:0] left_col,
    input  logic [mrp_pkg::IDX_W-1:0] bottom_row,
    input  logic [mrp_pkg::IDX_W-1:0] right_col,
    input  logic [mrp_pkg::CNT_W-1:0] rows_eff,
    input  logic [mrp_pkg::CNT_W-1:0] cols_eff,
    output logic                      busy,
    output logic                      q_valid,
    output mrp_pkg::item_t            q_item,
    input  logic                      q_pop
);
    import mrp_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    item_t             fifo_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    item_t             item_in;
    logic              push;

    // Classify the incoming beat
    always_comb
    begin
        item_in.is_query   = (cmd_t'(cmd) == CMD_QUERY);
        item_in.bad        = ({1'b0, bottom_row} >= rows_eff) ||
                             ({1'b0, right_col} >= cols_eff) ||
                             (top_row > bottom_row) ||
                             (left_col > right_col);
        item_in.value      = (elem_value >= PRIME) ? elem_value - PRIME : elem_value;
        item_in.top_row    = top_row;
        item_in.left_col   = left_col;
        item_in.bottom_row = bottom_row;
        item_in.right_col  = right_col;
    end

    assign busy    = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    // Hold queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/mrp_back.sv =====
// ----------------------------------------------------------------------------
// mrp_back
// Builds the prefix product table on loads and answers rectangle queries.
// ----------------------------------------------------------------------------
module mrp_back #(
    parameter int unsigned MAX_ROWS = mrp_pkg::DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS = mrp_pkg::DEF_MAX_COLS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  mrp_pkg::item_t            q_item,
    output logic                      q_pop,
    input  logic [mrp_pkg::CNT_W-1:0] rows_eff,
    input  logic [mrp_pkg::CNT_W-1:0] cols_eff,
    input  logic                      cfg_clr,
    output logic                      done,
    output logic [mrp_pkg::VAL_W-1:0] range_product,
    output logic                      bad_query
);
    import mrp_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_COL,
        ST_LD_COLW,
        ST_LD_ROW,
        ST_LD_ROWW,
        ST_Q_SEL,
        ST_Q_DAT,
        ST_Q_INVW,
        ST_Q_MULW,
        ST_Q_OUT
    } state_t;

    state_t           state_reg;
    item_t            item_reg;
    logic [1:0]       step_reg;
    logic [RW-1:0]    load_row_reg;
    logic [CW-1:0]    load_col_reg;
    logic [RW-1:0]    pos_r_reg;
    logic [CW-1:0]    pos_c_reg;
    logic [VAL_W-1:0] row_running_reg;
    logic [VAL_W-1:0] colval_reg;
    logic [VAL_W-1:0] acc_reg;
    logic             done_reg;
    logic             bad_reg;
    logic [VAL_W-1:0] product_reg;

    logic [VAL_W-1:0] tbl_mem [DEPTH];
    logic [VAL_W-1:0] col_mem [MAX_COLS];
    logic [VAL_W-1:0] tbl_q;
    logic [VAL_W-1:0] col_q;
    logic [AW-1:0]    tbl_raddr;
    logic [AW-1:0]    tbl_waddr;
    logic             tbl_we;
    logic             col_we;

    logic             mul_start;
    logic [VAL_W-1:0] mul_a;
    logic [VAL_W-1:0] mul_b;
    logic             mul_done;
    logic [VAL_W-1:0] mul_y;
    logic             inv_start;
    logic             inv_done;
    logic [VAL_W-1:0] inv_y;

    logic [IDX_W-1:0] sel_row;
    logic [IDX_W-1:0] sel_col;
    logic             step_need;
    logic             wrap_pos;
    logic [15:0]      next_c;
    logic [15:0]      next_r;

    function automatic logic [AW-1:0] cell_addr(input logic [15:0] r,
                                                input logic [15:0] c);
        logic [31:0] a;
        a = 32'(r) * 32'(MAX_COLS) + 32'(c);
        return a[AW-1:0];
    endfunction

    // Pick the table cell of the current query step
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                sel_row   = item_reg.bottom_row;
                sel_col   = item_reg.right_col;
                step_need = 1'b1;
            end
            2'd1:
            begin
                sel_row   = item_reg.top_row - 1'b1;
                sel_col   = item_reg.left_col - 1'b1;
                step_need = (item_reg.top_row != '0) && (item_reg.left_col != '0);
            end
            2'd2:
            begin
                sel_row   = item_reg.top_row - 1'b1;
                sel_col   = item_reg.right_col;
                step_need = (item_reg.top_row != '0);
            end
            default:
            begin
                sel_row   = item_reg.bottom_row;
                sel_col   = item_reg.left_col - 1'b1;
                step_need = (item_reg.left_col != '0);
            end
        endcase
    end

    assign tbl_raddr = cell_addr(16'(sel_row), 16'(sel_col));
    assign tbl_waddr = cell_addr(16'(pos_r_reg), 16'(pos_c_reg));
    assign tbl_we    = (state_reg == ST_LD_ROWW) && mul_done;
    assign col_we    = (state_reg == ST_LD_COLW) && mul_done;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign wrap_pos  = (16'(load_row_reg) >= 16'(rows_eff)) ||
                       (16'(load_col_reg) >= 16'(cols_eff));
    assign next_c    = 16'(pos_c_reg) + 16'd1;
    assign next_r    = 16'(pos_r_reg) + 16'd1;

    // Steer the shared multiplier and the inverse unit
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = acc_reg;
        mul_b     = tbl_q;
        inv_start = 1'b0;
        unique case (state_reg)
            ST_LD_COL:
            begin
                mul_start = 1'b1;
                mul_a     = item_reg.value;
                mul_b     = (pos_r_reg == '0) ? VAL_W'(1) : col_q;
            end
            ST_LD_ROW:
            begin
                mul_start = 1'b1;
                mul_a     = colval_reg;
                mul_b     = (pos_c_reg == '0) ? VAL_W'(1) : row_running_reg;
            end
            ST_Q_DAT:
            begin
                mul_start = (step_reg == 2'd1);
                inv_start = step_reg[1];
            end
            ST_Q_INVW:
            begin
                mul_start = inv_done;
                mul_b     = inv_y;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Prefix table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= mul_y;
        end
        tbl_q <= tbl_mem[tbl_raddr];
    end

    // Column running products
    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[pos_c_reg] <= mul_y;
        end
        col_q <= col_mem[pos_c_reg];
    end

    // Sequence loads and queries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            load_row_reg    <= '0;
            load_col_reg    <= '0;
            row_running_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg <= q_item;
                        step_reg <= '0;
                        if (q_item.is_query)
                        begin
                            if (q_item.bad)
                            begin
                                done_reg    <= 1'b1;
                                bad_reg     <= 1'b1;
                                product_reg <= '0;
                            end
                            else
                            begin
                                state_reg <= ST_Q_SEL;
                            end
                        end
                        else
                        begin
                            pos_r_reg <= wrap_pos ? '0 : load_row_reg;
                            pos_c_reg <= wrap_pos ? '0 : load_col_reg;
                            state_reg <= ST_LD_RD;
                        end
                    end
                end
                ST_LD_RD:
                begin
                    state_reg <= ST_LD_COL;
                end
                ST_LD_COL:
                begin
                    state_reg <= ST_LD_COLW;
                end
                ST_LD_COLW:
                begin
                    if (mul_done)
                    begin
                        colval_reg <= mul_y;
                        state_reg  <= ST_LD_ROW;
                    end
                end
                ST_LD_ROW:
                begin
                    state_reg <= ST_LD_ROWW;
                end
                ST_LD_ROWW:
                begin
                    if (mul_done)
                    begin
                        row_running_reg <= mul_y;
                        if (next_c >= 16'(cols_eff))
                        begin
                            load_col_reg <= '0;
                            load_row_reg <= (next_r >= 16'(rows_eff)) ? '0 : next_r[RW-1:0];
                        end
                        else
                        begin
                            load_col_reg <= next_c[CW-1:0];
                            load_row_reg <= pos_r_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_Q_SEL:
                begin
                    if (step_need)
                    begin
                        state_reg <= ST_Q_DAT;
                    end
                    else if (step_reg == 2'd3)
                    begin
                        state_reg <= ST_Q_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_Q_DAT:
                begin
                    priority if (step_reg == 2'd0)
                    begin
                        acc_reg   <= tbl_q;
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_Q_SEL;
                    end
                    else if (step_reg[1])
                    begin
                        state_reg <= ST_Q_INVW;
                    end
                    else
                    begin
                        state_reg <= ST_Q_MULW;
                    end
                end
                ST_Q_INVW:
                begin
                    if (inv_done)
                    begin
                        state_reg <= ST_Q_MULW;
                    end
                end
                ST_Q_MULW:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= mul_y;
                        if (step_reg == 2'd3)
                        begin
                            state_reg <= ST_Q_OUT;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= ST_Q_SEL;
                        end
                    end
                end
                ST_Q_OUT:
                begin
                    done_reg    <= 1'b1;
                    bad_reg     <= 1'b0;
                    product_reg <= acc_reg;
                    state_reg   <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // Drop the load position on a register write
            if (cfg_clr)
            begin
                load_row_reg <= '0;
                load_col_reg <= '0;
            end
        end
    end

    mrp_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .y     (mul_y)
    );

    mrp_inv u_inv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (inv_start),
        .a     (tbl_q),
        .done  (inv_done),
        .y     (inv_y)
    );

    assign done          = done_reg;
    assign range_product = product_reg;
    assign bad_query     = bad_reg;

endmodule

// ===== rtl/modular_2d_range_product_top.sv =====
// ----------------------------------------------------------------------------
// modular_2d_range_product_top
// Two-dimensional prefix products modulo 1000000007 with rectangle queries.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken when start is high and busy is low.
//   cmd = load appends elem_value to the matrix in row-major order and gives
//   no result; cmd = query returns one result on range_product / bad_query,
//   shown for one cycle while done is high. Results come in command order.
//   Registers row_count (0x0) and col_count (0x4) sit on the APB port; a
//   write also returns the load position to row 0, column 0. Write them
//   only while no command is in flight.
// Timing:
//   A two-entry queue sits between the command front and the execution
//   back, so up to two commands are taken while the back is working.
//   A load runs two modular multiplies, one after the other.
//   A bad query is answered from the idle state with no arithmetic.
//   A good query runs up to three multiplies and up to two inverses by
//   binary Euclid; a rectangle at the origin needs none of them.
// Reset:
//   Counts return to 64, the load position to the origin, the queue empties.
//   The table holds no valid data until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module modular_2d_range_product_top #(
    parameter int unsigned MAX_ROWS = mrp_pkg::DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS = mrp_pkg::DEF_MAX_COLS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cmd,
    input  logic [mrp_pkg::VAL_W-1:0] elem_value,
    input  logic [mrp_pkg::IDX_W-1:0] top_row,
    input  logic [mrp_pkg::IDX_W-1:0] left_col,
    input  logic [mrp_pkg::IDX_W-1:0] bottom_row,
    input  logic [mrp_pkg::IDX_W-1:0] right_col,
    output logic                      done,
    output logic [mrp_pkg::VAL_W-1:0] range_product,
    output logic                      bad_query,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import mrp_pkg::*;

    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] col_count_reg;
    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;
    logic             cfg_wr;
    reg_idx_t         reg_sel;
    logic             q_valid;
    item_t            q_item;
    logic             q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    // Hold the count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(64);
            col_count_reg <= CNT_W'(64);
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_ROW_COUNT: row_count_reg <= pwdata[CNT_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[CNT_W-1:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_sel)
            REG_ROW_COUNT: prdata = 32'(row_count_reg);
            REG_COL_COUNT: prdata = 32'(col_count_reg);
        endcase
    end

    // Clamp the counts to 1..MAX
    assign rows_eff = (row_count_reg == '0) ? CNT_W'(1) :
                      (32'(row_count_reg) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) :
                      row_count_reg;
    assign cols_eff = (col_count_reg == '0) ? CNT_W'(1) :
                      (32'(col_count_reg) > 32'(MAX_COLS)) ? CNT_W'(MAX_COLS) :
                      col_count_reg;

    mrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .elem_value (elem_value),
        .top_row    (top_row),
        .left_col   (left_col),
        .bottom_row (bottom_row),
        .right_col  (right_col),
        .rows_eff   (rows_eff),
        .cols_eff   (cols_eff),
        .busy       (busy),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    mrp_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .rows_eff      (rows_eff),
        .cols_eff      (cols_eff),
        .cfg_clr       (cfg_wr),
        .done          (done),
        .range_product (range_product),
        .bad_query     (bad_query)
    );

endmodule

// ===== rtl/mrp_checker.sv =====
// ----------------------------------------------------------------------------
// mrp_checker
// Port-level checks of the rectangle product block, bound to the top level.
// ----------------------------------------------------------------------------
`include "modular_2d_range_product_top_assert.svh"

module mrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic        bad_query,
    input logic [29:0] range_product,
    input logic [31:0] prdata
);

    // A rejected query always carries a zero product
    `MRP_ASSERT_IMP(a_bad_zero, done && bad_query, range_product == 30'd0, "bad query with nonzero product")

    // A good answer is a residue of the prime
    `MRP_ASSERT_IMP(a_residue, done && !bad_query, range_product < 30'd1000000007, "product not reduced")

    // Register readback never shows bits above the count width
    `MRP_ASSERT_NEXT(a_prdata, 1'b1, prdata[31:7] == 25'd0, "readback upper bits set")

endmodule

bind modular_2d_range_product_top mrp_checker u_mrp_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle product testbench
// Loads small matrices through the command port and asks rectangle queries.
// Each answer is checked against a local model of the prefix product table
// kept modulo 1000000007. The matrix size is changed over the APB port
// between phases, and the sender idles at random.
// ----------------------------------------------------------------------------
module tb;
    import mrp_pkg::*;

    localparam longint MODULUS = 64'd1000000007;

    typedef struct {
        logic [VAL_W-1:0] product;
        logic             bad;
    } answer_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             cmd;
    logic [VAL_W-1:0] elem_value;
    logic [IDX_W-1:0] top_row;
    logic [IDX_W-1:0] left_col;
    logic [IDX_W-1:0] bottom_row;
    logic [IDX_W-1:0] right_col;
    logic             done;
    logic [VAL_W-1:0] range_product;
    logic             bad_query;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    // Local copy of the block state
    longint           prefix_grid [64][64];
    longint           col_product [64];
    longint           row_product;
    int               next_row;
    int               next_col;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_reg;

    answer_t          pending_answers[$];
    int               error_count;
    int               idle_pct;

    modular_2d_range_product_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .elem_value   (elem_value),
        .top_row      (top_row),
        .left_col     (left_col),
        .bottom_row   (bottom_row),
        .right_col    (right_col),
        .done         (done),
        .range_product(range_product),
        .bad_query    (bad_query),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 clk = ~clk;

    function automatic longint mul_mod(longint a, longint b);
        return (a * b) % MODULUS;
    endfunction

    // Extended Euclid; zero has no inverse and maps to zero
    function automatic longint inv_mod(longint a);
        longint r0;
        longint r1;
        longint t0;
        longint t1;
        longint q;
        longint tmp;
        r0 = MODULUS;
        r1 = a % MODULUS;
        t0 = 0;
        t1 = 1;
        if (r1 == 0)
            return 0;
        while (r1 != 0)
        begin
            q   = r0 / r1;
            tmp = r0 - q * r1;
            r0  = r1;
            r1  = tmp;
            tmp = t0 - q * t1;
            t0  = t1;
            t1  = tmp;
        end
        t0 = t0 % MODULUS;
        if (t0 < 0)
            t0 += MODULUS;
        return t0;
    endfunction

    function automatic int rows_in_use();
        if (row_reg == 0)
            return 1;
        return (row_reg > 64) ? 64 : int'(row_reg);
    endfunction

    function automatic int cols_in_use();
        if (col_reg == 0)
            return 1;
        return (col_reg > 64) ? 64 : int'(col_reg);
    endfunction

    // Advance the table by one loaded element
    function automatic void absorb_element(logic [VAL_W-1:0] raw);
        longint v;
        int     r;
        int     c;
        v = longint'(raw) % MODULUS;
        r = next_row;
        c = next_col;
        if (r >= rows_in_use() || c >= cols_in_use())
        begin
            r = 0;
            c = 0;
        end
        col_product[c]   = (r == 0) ? v : mul_mod(v, col_product[c]);
        row_product      = (c == 0) ? col_product[c] : mul_mod(row_product, col_product[c]);
        prefix_grid[r][c] = row_product;
        c++;
        if (c >= cols_in_use())
        begin
            c = 0;
            r++;
            if (r >= rows_in_use())
                r = 0;
        end
        next_row = r;
        next_col = c;
    endfunction

    // Work out the rectangle answer by inclusion-exclusion
    function automatic answer_t rectangle_answer(int t, int l, int b, int rc);
        answer_t a;
        longint  p;
        if (b >= rows_in_use() || rc >= cols_in_use() || t > b || l > rc)
        begin
            a.product = '0;
            a.bad     = 1'b1;
            return a;
        end
        p = prefix_grid[b][rc];
        if (t > 0 && l > 0)
            p = mul_mod(p, prefix_grid[t-1][l-1]);
        if (t > 0)
            p = mul_mod(p, inv_mod(prefix_grid[t-1][rc]));
        if (l > 0)
            p = mul_mod(p, inv_mod(prefix_grid[b][l-1]));
        a.product = VAL_W'(p);
        a.bad     = 1'b0;
        return a;
    endfunction

    // Send one beat, holding start until it is taken
    task automatic send_beat(cmd_t op, logic [VAL_W-1:0] v,
                             int t, int l, int b, int rc);
        bit taken;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        elem_value <= v;
        top_row    <= IDX_W'(t);
        left_col   <= IDX_W'(l);
        bottom_row <= IDX_W'(b);
        right_col  <= IDX_W'(rc);
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        if (op == CMD_LOAD)
            absorb_element(v);
        else
            pending_answers.push_back(rectangle_answer(t, l, b, rc));
    endtask

    task automatic load_value(logic [VAL_W-1:0] v);
        send_beat(CMD_LOAD, v, $urandom_range(63), $urandom_range(63),
                  $urandom_range(63), $urandom_range(63));
    endtask

    task automatic ask(int t, int l, int b, int rc);
        send_beat(CMD_QUERY, VAL_W'($urandom), t, l, b, rc);
    endtask

    function automatic logic [VAL_W-1:0] random_element();
        case ($urandom_range(15))
            0:       return '0;
            1:       return VAL_W'($urandom_range(32'h3FFF_FFFF, 32'd1000000007));
            2:       return VAL_W'(1);
            default: return VAL_W'($urandom_range(32'd1000000006, 1));
        endcase
    endfunction

    // Drain the block, then write one register
    task automatic write_register(reg_idx_t idx, logic [CNT_W-1:0] v);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx) * 3'd4;
        pwdata  <= {$urandom} & ~32'h7F | 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROW_COUNT)
            row_reg = v;
        else
            col_reg = v;
        next_row = 0;
        next_col = 0;
    endtask

    task automatic set_size(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
        write_register(REG_ROW_COUNT, rows);
        write_register(REG_COL_COUNT, cols);
    endtask

    task automatic fill_table();
        repeat (rows_in_use() * cols_in_use()) load_value(random_element());
    endtask

    // Extremes of the element, every bad-corner case, zero propagation, wrap
    task automatic test_directed();
        idle_pct = 0;
        set_size(7'd3, 7'd4);
        load_value(VAL_W'(1000000006));
        load_value(VAL_W'(30'h3FFF_FFFF));
        load_value(VAL_W'(1000000007));
        load_value(VAL_W'(2));
        repeat (8) load_value(random_element());
        ask(0, 0, 2, 3);
        ask(1, 1, 2, 3);
        ask(2, 3, 2, 3);
        ask(0, 1, 1, 3);
        ask(1, 0, 2, 0);
        ask(3, 0, 3, 0);
        ask(0, 4, 0, 4);
        ask(2, 0, 1, 3);
        ask(0, 3, 2, 2);
        ask(63, 63, 63, 63);
        // Wrap past the last cell and overwrite row 0 with values
        load_value(VAL_W'(5));
        load_value(VAL_W'(7));
        ask(0, 0, 0, 1);
        ask(1, 1, 2, 2);
    endtask

    // Count zero acts as one and counts beyond the table clip to 64
    task automatic test_count_extremes();
        idle_pct = 22;
        set_size(7'd0, 7'd127);
        fill_table();
        ask(0, 0, 0, 63);
        ask(0, 17, 0, 40);
        ask(0, 63, 0, 63);
        ask(1, 0, 1, 0);
        set_size(7'd127, 7'd1);
        fill_table();
        ask(0, 0, 63, 0);
        ask(30, 0, 63, 0);
        ask(0, 0, 0, 1);
        set_size(7'd64, 7'd64);
        set_size(7'd1, 7'd1);
        fill_table();
        ask(0, 0, 0, 0);
    endtask

    // Random loads and rectangles, some out of range, over a freshly loaded table of random size
    task automatic test_random_phase(int pct, int beats);
        int rows;
        int cols;
        int t;
        int l;
        int b;
        int rc;
        idle_pct = pct;
        set_size(CNT_W'($urandom_range(8, 1)), CNT_W'($urandom_range(8, 1)));
        fill_table();
        rows = rows_in_use();
        cols = cols_in_use();
        repeat (beats)
        begin
            case ($urandom_range(9))
                0, 1:
                    load_value(random_element());
                2:
                    ask($urandom_range(63), $urandom_range(63),
                        $urandom_range(63), $urandom_range(63));
                default:
                begin
                    t  = $urandom_range(rows - 1);
                    b  = $urandom_range(rows - 1, t);
                    l  = $urandom_range(cols - 1);
                    rc = $urandom_range(cols - 1, l);
                    ask(t, l, b, rc);
                end
            endcase
        end
    endtask

    // Compare each result beat against the oldest expectation
    always @(negedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result beat with nothing expected: range_product %0d", range_product);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (range_product !== want.product)
                begin
                    $error("range_product expected %0d actual %0d", want.product, range_product);
                    error_count++;
                end
                if (bad_query !== want.bad)
                begin
                    $error("bad_query expected %0d actual %0d", want.bad, bad_query);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_LOAD;
        elem_value  = '0;
        top_row     = '0;
        left_col    = '0;
        bottom_row  = '0;
        right_col   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        error_count = 0;
        idle_pct    = 0;
        row_reg     = 7'd64;
        col_reg     = 7'd64;
        next_row    = 0;
        next_col    = 0;
        row_product = 0;
        for (int r = 0; r < 64; r++)
        begin
            col_product[r] = 0;
            for (int c = 0; c < 64; c++)
                prefix_grid[r][c] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_count_extremes();
        test_random_phase(0, 30);
        test_random_phase(45, 30);
        test_random_phase(0, 30);
        test_random_phase(22, 30);
        test_random_phase(45, 30);

        // Drain and let the last beat settle
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== modular_2d_range_product_top.f =====
+incdir+rtl
rtl/mrp_pkg.sv
rtl/mrp_mulmod.sv
rtl/mrp_inv.sv
rtl/mrp_front.sv
rtl/mrp_back.sv
rtl/modular_2d_range_product_top.sv
rtl/mrp_checker.sv
sim/tb.sv
